FILE: hdl/tsk_pkg.sv
// shared types and codes for the topological sort block
`default_nettype none
package tsk_pkg;

	typedef enum logic [1:0] {
		MODE_ADD_NODE = 2'd0,
		MODE_ADD_EDGE = 2'd1,
		MODE_RUN      = 2'd2,
		MODE_CLEAR    = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		SEL_J = 3'd0,
		SEL_I = 3'd1,
		SEL_A = 3'd2,
		SEL_Q = 3'd3,
		SEL_H = 3'd4
	} rd_sel_t;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] node_label;
		logic [7:0] edge_from;
		logic [7:0] edge_to;
	} tsk_item_t;

	typedef struct packed {
		logic [7:0] sorted_label;
		logic       cycle_error;
		logic       last;
	} tsk_result_t;

	typedef struct packed {
		logic    take_item;
		logic    clr_n;
		logic    wr_node;
		logic    j_clr;
		logic    j_inc;
		logic    i_clr;
		logic    i_inc;
		logic    k_clr;
		logic    k_inc;
		rd_sel_t rd_sel;
		logic    lab_rd;
		logic    adj_rd;
		logic    fifo_rd;
		logic    rank_rd;
		logic    cmp_edge;
		logic    adj_wr_edge;
		logic    lab_i_ld;
		logic    cnt_clr;
		logic    cnt_acc;
		logic    rank_wr;
		logic    deg_clr;
		logic    deg_add;
		logic    q_clr;
		logic    qi_chk;
		logic    s_step;
		logic    sc_chk;
		logic    out_ld_ok;
		logic    out_ld_err;
	} tsk_cmd_t;

	typedef struct packed {
		logic n_zero;
		logic n_full;
		logic j_last;
		logic i_last;
		logic k_last;
		logic dup_hit;
		logic edge_ok;
		logic q_more;
		logic sort_ok;
		logic out_full;
	} tsk_status_t;

endpackage
`default_nettype wire

FILE: hdl/tsk_stream_if.sv
// valid/ready stream channel
`default_nettype none
interface tsk_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hdl/topological_sort_kahn_top.sv
// top level of the topological sort block
//
//  channel  dir  payload                                  transaction
//  item     in   mode, node_label, edge_from, edge_to     item.valid && item.ready
//  result   out  sorted_label, cycle_error, last          result.valid && result.ready
//
// add node and add edge scan the n stored labels one slot at a time through
// the registered read port of the label memory. the length of a run is set
// mostly by the rank pass and the successor scans, each of which reads one
// memory word at a time; clear resets the node count without leaving idle.
// items are taken only while idle; a result waits in the output register and
// a held result stalls the next one. reset needs no clearing pass.
`default_nettype none
module topological_sort_kahn_top #(
	parameter int MAX_NODES  = 16,
	parameter int LABEL_BITS = 8
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	tsk_stream_if.sink   item,
	tsk_stream_if.source result
);
	import tsk_pkg::*;

	tsk_cmd_t    cmd;
	tsk_status_t status;
	tsk_item_t   item_data;
	tsk_result_t out_data;
	logic        in_ready;
	logic        out_valid;

	assign item_data = item.data;
	assign item.ready = in_ready;
	assign result.valid = out_valid;
	assign result.data = out_data;

	tsk_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_mode  (item_data.mode),
		.in_ready (in_ready),
		.cmd      (cmd),
		.status   (status)
	);

	tsk_dpath #(
		.MAX_NODES  (MAX_NODES),
		.LABEL_BITS (LABEL_BITS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.item_data (item_data),
		.out_valid (out_valid),
		.out_ready (result.ready),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire

FILE: hdl/tsk_dpath.sv
// datapath: node table, adjacency rows, rank table, ready queue, in-degree counters
`default_nettype none
module tsk_dpath #(
	parameter int MAX_NODES  = 16,
	parameter int LABEL_BITS = 8
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  tsk_pkg::tsk_cmd_t         cmd,
	output tsk_pkg::tsk_status_t      status,
	input  tsk_pkg::tsk_item_t        item_data,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output tsk_pkg::tsk_result_t      out_data
);
	import tsk_pkg::*;

	localparam int IDX = $clog2(MAX_NODES);
	localparam int CNT = $clog2(MAX_NODES + 1);
	localparam logic [CNT-1:0] N_MAX = CNT'(MAX_NODES);
	localparam logic [CNT-1:0] ONE = CNT'(1);

	logic [LABEL_BITS-1:0] lab_mem [MAX_NODES];
	logic [MAX_NODES-1:0]  adj_mem [MAX_NODES];
	logic [IDX-1:0]        rank_mem [MAX_NODES];
	logic [IDX-1:0]        fifo_mem [MAX_NODES];
	logic [CNT-1:0]        indeg_q [MAX_NODES];

	logic [LABEL_BITS-1:0] lab_rd_q, lab_i_q;
	logic [MAX_NODES-1:0]  adj_rd_q;
	logic [IDX-1:0]        rank_rd_q, fifo_rd_q;
	logic [LABEL_BITS-1:0] key_lab_q, key_from_q, key_to_q;
	logic [IDX-1:0]        a_q, b_q;
	logic                  a_found_q, b_found_q;
	logic [CNT-1:0]        n_q, j_q, i_q, k_q, cnt_q, head_q, tail_q;
	logic                  out_valid_q;
	tsk_result_t           out_data_q;

	logic [LABEL_BITS-1:0] in_lab, in_from, in_to;
	logic [15:0]           ext_lab, ext_from, ext_to, out_ext;
	logic [IDX-1:0]        lab_addr, adj_addr, fifo_addr, t_idx;
	logic [MAX_NODES-1:0]  b_bit;
	logic [CNT-1:0]        dec_val;
	logic                  push;

	// labels masked to the configured width
	always_comb begin
		ext_lab  = {8'b0, item_data.node_label};
		ext_from = {8'b0, item_data.edge_from};
		ext_to   = {8'b0, item_data.edge_to};
		in_lab   = ext_lab[LABEL_BITS-1:0];
		in_from  = ext_from[LABEL_BITS-1:0];
		in_to    = ext_to[LABEL_BITS-1:0];
		out_ext  = 16'(lab_rd_q);
	end

	always_comb begin
		case (cmd.rd_sel)
			SEL_I:   lab_addr = i_q[IDX-1:0];
			SEL_Q:   lab_addr = fifo_rd_q;
			default: lab_addr = j_q[IDX-1:0];
		endcase
		case (cmd.rd_sel)
			SEL_A:   adj_addr = a_q;
			SEL_Q:   adj_addr = fifo_rd_q;
			default: adj_addr = j_q[IDX-1:0];
		endcase
		case (cmd.rd_sel)
			SEL_I:   fifo_addr = i_q[IDX-1:0];
			default: fifo_addr = head_q[IDX-1:0];
		endcase
		b_bit = '0;
		b_bit[b_q] = 1'b1;
		t_idx = rank_rd_q;
		dec_val = (indeg_q[t_idx] != '0) ? indeg_q[t_idx] - ONE : '0;
		push = ((cmd.qi_chk && indeg_q[t_idx] == '0)
			|| (cmd.sc_chk && adj_rd_q[t_idx] && dec_val == '0)) && (tail_q < N_MAX);
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_node)
			lab_mem[n_q[IDX-1:0]] <= key_lab_q;
		if (cmd.lab_rd)
			lab_rd_q <= lab_mem[lab_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_node)
			adj_mem[n_q[IDX-1:0]] <= '0;
		else if (cmd.adj_wr_edge)
			adj_mem[a_q] <= adj_rd_q | b_bit;
		if (cmd.adj_rd)
			adj_rd_q <= adj_mem[adj_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.rank_wr)
			rank_mem[cnt_q[IDX-1:0]] <= i_q[IDX-1:0];
		if (cmd.rank_rd)
			rank_rd_q <= rank_mem[k_q[IDX-1:0]];
	end

	always_ff @(posedge clk) begin
		if (push)
			fifo_mem[tail_q[IDX-1:0]] <= t_idx;
		if (cmd.fifo_rd)
			fifo_rd_q <= fifo_mem[fifo_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.deg_clr) begin
			for (int l = 0; l < MAX_NODES; l++)
				indeg_q[l] <= '0;
		end else if (cmd.deg_add) begin
			for (int l = 0; l < MAX_NODES; l++)
				indeg_q[l] <= indeg_q[l] + CNT'(adj_rd_q[l]);
		end else if (cmd.sc_chk && adj_rd_q[t_idx]) begin
			indeg_q[t_idx] <= dec_val;
		end
	end

	// payload, lookup and result holding registers
	always_ff @(posedge clk) begin
		if (cmd.take_item) begin
			key_lab_q  <= in_lab;
			key_from_q <= in_from;
			key_to_q   <= in_to;
		end
		if (cmd.lab_i_ld)
			lab_i_q <= lab_rd_q;
		if (cmd.cmp_edge && lab_rd_q == key_from_q)
			a_q <= j_q[IDX-1:0];
		if (cmd.cmp_edge && lab_rd_q == key_to_q)
			b_q <= j_q[IDX-1:0];
		if (cmd.out_ld_err)
			out_data_q <= '{sorted_label: 8'd0, cycle_error: 1'b1, last: 1'b1};
		else if (cmd.out_ld_ok)
			out_data_q <= '{sorted_label: out_ext[7:0], cycle_error: 1'b0,
				last: status.i_last};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q         <= '0;
			j_q         <= '0;
			i_q         <= '0;
			k_q         <= '0;
			cnt_q       <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			a_found_q   <= 1'b0;
			b_found_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_n)
				n_q <= '0;
			else if (cmd.wr_node)
				n_q <= n_q + ONE;
			if (cmd.j_clr)
				j_q <= '0;
			else if (cmd.j_inc)
				j_q <= j_q + ONE;
			if (cmd.i_clr)
				i_q <= '0;
			else if (cmd.i_inc)
				i_q <= i_q + ONE;
			if (cmd.k_clr)
				k_q <= '0;
			else if (cmd.k_inc)
				k_q <= k_q + ONE;
			if (cmd.cnt_clr)
				cnt_q <= '0;
			else if (cmd.cnt_acc)
				cnt_q <= cnt_q + CNT'(lab_rd_q < lab_i_q);
			if (cmd.q_clr) begin
				head_q <= '0;
				tail_q <= '0;
			end else begin
				if (cmd.s_step)
					head_q <= head_q + ONE;
				if (push)
					tail_q <= tail_q + ONE;
			end
			if (cmd.take_item) begin
				a_found_q <= 1'b0;
				b_found_q <= 1'b0;
			end else if (cmd.cmp_edge) begin
				if (lab_rd_q == key_from_q)
					a_found_q <= 1'b1;
				if (lab_rd_q == key_to_q)
					b_found_q <= 1'b1;
			end
			if (cmd.out_ld_ok || cmd.out_ld_err)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		status.n_zero   = (n_q == '0);
		status.n_full   = (n_q == N_MAX);
		status.j_last   = ((j_q + ONE) == n_q);
		status.i_last   = ((i_q + ONE) == n_q);
		status.k_last   = ((k_q + ONE) == n_q);
		status.dup_hit  = (lab_rd_q == key_lab_q);
		status.edge_ok  = a_found_q && b_found_q;
		status.q_more   = (head_q < tail_q) && (head_q < N_MAX);
		status.sort_ok  = (head_q == n_q);
		status.out_full = out_valid_q;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule
`default_nettype wire

FILE: hdl/tsk_ctrl.sv
// controller state machine sequencing loads, the sort passes and the result stream
`default_nettype none
module tsk_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	input  wire logic [1:0]      in_mode,
	output logic                 in_ready,
	output tsk_pkg::tsk_cmd_t    cmd,
	input  tsk_pkg::tsk_status_t status
);
	import tsk_pkg::*;

	typedef enum logic [27:0] {
		S_IDLE    = 28'h0000001,
		S_FN_RD   = 28'h0000002,
		S_FN_CMP  = 28'h0000004,
		S_NODE_WR = 28'h0000008,
		S_ED_RD   = 28'h0000010,
		S_ED_CMP  = 28'h0000020,
		S_ED_CHK  = 28'h0000040,
		S_ED_WR   = 28'h0000080,
		S_RK_LI   = 28'h0000100,
		S_RK_LW   = 28'h0000200,
		S_RK_RD   = 28'h0000400,
		S_RK_CMP  = 28'h0000800,
		S_RK_WR   = 28'h0001000,
		S_DG_INIT = 28'h0002000,
		S_DG_RD   = 28'h0004000,
		S_DG_ADD  = 28'h0008000,
		S_QI_INIT = 28'h0010000,
		S_QI_RD   = 28'h0020000,
		S_QI_CHK  = 28'h0040000,
		S_DQ      = 28'h0080000,
		S_DQ_S    = 28'h0100000,
		S_SC_RD   = 28'h0200000,
		S_SC_CHK  = 28'h0400000,
		S_FIN     = 28'h0800000,
		S_ERR     = 28'h1000000,
		S_EM_RD   = 28'h2000000,
		S_EM_LR   = 28'h4000000,
		S_EM_LD   = 28'h8000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.take_item = 1'b1;
					case (in_mode)
						MODE_ADD_NODE: begin
							if (status.n_full)
								state_d = S_IDLE;
							else if (status.n_zero)
								state_d = S_NODE_WR;
							else begin
								cmd.j_clr = 1'b1;
								state_d = S_FN_RD;
							end
						end
						MODE_ADD_EDGE: begin
							if (!status.n_zero) begin
								cmd.j_clr = 1'b1;
								state_d = S_ED_RD;
							end
						end
						MODE_RUN: begin
							if (!status.n_zero) begin
								cmd.i_clr = 1'b1;
								state_d = S_RK_LI;
							end
						end
						default: cmd.clr_n = 1'b1;
					endcase
				end
			end
			// duplicate label search
			S_FN_RD: begin
				cmd.lab_rd = 1'b1;
				cmd.rd_sel = SEL_J;
				state_d = S_FN_CMP;
			end
			S_FN_CMP: begin
				cmd.j_inc = 1'b1;
				if (status.dup_hit)
					state_d = S_IDLE;
				else if (status.j_last)
					state_d = S_NODE_WR;
				else
					state_d = S_FN_RD;
			end
			S_NODE_WR: begin
				cmd.wr_node = 1'b1;
				state_d = S_IDLE;
			end
			// both endpoints looked up in one pass
			S_ED_RD: begin
				cmd.lab_rd = 1'b1;
				cmd.rd_sel = SEL_J;
				state_d = S_ED_CMP;
			end
			S_ED_CMP: begin
				cmd.cmp_edge = 1'b1;
				cmd.j_inc = 1'b1;
				state_d = status.j_last ? S_ED_CHK : S_ED_RD;
			end
			S_ED_CHK: begin
				if (status.edge_ok) begin
					cmd.adj_rd = 1'b1;
					cmd.rd_sel = SEL_A;
					state_d = S_ED_WR;
				end else
					state_d = S_IDLE;
			end
			S_ED_WR: begin
				cmd.adj_wr_edge = 1'b1;
				state_d = S_IDLE;
			end
			// rank of each slot = number of smaller labels
			S_RK_LI: begin
				cmd.lab_rd = 1'b1;
				cmd.rd_sel = SEL_I;
				state_d = S_RK_LW;
			end
			S_RK_LW: begin
				cmd.lab_i_ld = 1'b1;
				cmd.j_clr = 1'b1;
				cmd.cnt_clr = 1'b1;
				state_d = S_RK_RD;
			end
			S_RK_RD: begin
				cmd.lab_rd = 1'b1;
				cmd.rd_sel = SEL_J;
				state_d = S_RK_CMP;
			end
			S_RK_CMP: begin
				cmd.cnt_acc = 1'b1;
				cmd.j_inc = 1'b1;
				state_d = status.j_last ? S_RK_WR : S_RK_RD;
			end
			S_RK_WR: begin
				cmd.rank_wr = 1'b1;
				cmd.i_inc = 1'b1;
				state_d = status.i_last ? S_DG_INIT : S_RK_LI;
			end
			// column sums of the adjacency rows
			S_DG_INIT: begin
				cmd.deg_clr = 1'b1;
				cmd.j_clr = 1'b1;
				state_d = S_DG_RD;
			end
			S_DG_RD: begin
				cmd.adj_rd = 1'b1;
				cmd.rd_sel = SEL_J;
				state_d = S_DG_ADD;
			end
			S_DG_ADD: begin
				cmd.deg_add = 1'b1;
				cmd.j_inc = 1'b1;
				state_d = status.j_last ? S_QI_INIT : S_DG_RD;
			end
			S_QI_INIT: begin
				cmd.q_clr = 1'b1;
				cmd.k_clr = 1'b1;
				state_d = S_QI_RD;
			end
			S_QI_RD: begin
				cmd.rank_rd = 1'b1;
				state_d = S_QI_CHK;
			end
			S_QI_CHK: begin
				cmd.qi_chk = 1'b1;
				cmd.k_inc = 1'b1;
				state_d = status.k_last ? S_DQ : S_QI_RD;
			end
			S_DQ: begin
				if (status.q_more) begin
					cmd.fifo_rd = 1'b1;
					cmd.rd_sel = SEL_H;
					state_d = S_DQ_S;
				end else
					state_d = S_FIN;
			end
			S_DQ_S: begin
				cmd.s_step = 1'b1;
				cmd.adj_rd = 1'b1;
				cmd.rd_sel = SEL_Q;
				cmd.k_clr = 1'b1;
				state_d = S_SC_RD;
			end
			// successors scanned in rank order
			S_SC_RD: begin
				cmd.rank_rd = 1'b1;
				state_d = S_SC_CHK;
			end
			S_SC_CHK: begin
				cmd.sc_chk = 1'b1;
				cmd.k_inc = 1'b1;
				state_d = status.k_last ? S_DQ : S_SC_RD;
			end
			S_FIN: begin
				if (status.sort_ok) begin
					cmd.i_clr = 1'b1;
					state_d = S_EM_RD;
				end else
					state_d = S_ERR;
			end
			S_ERR: begin
				if (!status.out_full) begin
					cmd.out_ld_err = 1'b1;
					state_d = S_IDLE;
				end
			end
			// queue order is the sorted order
			S_EM_RD: begin
				cmd.fifo_rd = 1'b1;
				cmd.rd_sel = SEL_I;
				state_d = S_EM_LR;
			end
			S_EM_LR: begin
				cmd.lab_rd = 1'b1;
				cmd.rd_sel = SEL_Q;
				state_d = S_EM_LD;
			end
			S_EM_LD: begin
				if (!status.out_full) begin
					cmd.out_ld_ok = 1'b1;
					cmd.i_inc = 1'b1;
					state_d = status.i_last ? S_IDLE : S_EM_RD;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule
`default_nettype wire
